// ===== sv/ntt_dm_pkg.sv =====
// Shared types and constants of the transform-based decimal multiplier.
package ntt_dm_pkg;

    localparam int MW                 = 30;
    localparam int DIGIT_W            = 4;
    localparam int CARRY_W            = 31;
    localparam int DEFAULT_MAX_DIGITS = 1024;
    localparam int DEFAULT_DIGIT_BASE = 10;

    localparam logic [MW-1:0] MOD_P    = 30'd998244353;
    localparam logic [MW-1:0] ROOT_FWD = 30'd3;
    localparam logic [MW-1:0] ROOT_INV = 30'd332748118;

    typedef enum logic [1:0] {
        CMD_LOAD_A,
        CMD_LOAD_B,
        CMD_MULTIPLY,
        CMD_READ
    } cmd_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_READ,
        ST_EMPTY,
        ST_SIZE,
        ST_PAD,
        ST_BR_IDX,
        ST_BR_RI,
        ST_BR_RJ,
        ST_BR_WI,
        ST_BR_WJ,
        ST_STAGE,
        ST_POW_CHK,
        ST_POW_ACC,
        ST_POW_SQ,
        ST_POW_BASE,
        ST_BF_RU,
        ST_BF_RV,
        ST_BF_MUL,
        ST_BF_WU,
        ST_BF_WV,
        ST_W_UPD,
        ST_PW_RD,
        ST_PW_MUL,
        ST_PW_WR,
        ST_SC_RD,
        ST_SC_MUL,
        ST_SC_WR,
        ST_CY_NEXT,
        ST_CY_LD,
        ST_DIV,
        ST_CY_WR,
        ST_MUL,
        ST_FINISH
    } state_t;

endpackage

// ===== sv/ntt_dm_ram.sv =====
// Generic simple dual-port RAM with registered read.
module ntt_dm_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/ntt_decimal_multiplier_top.sv =====
// Signed decimal multiplier using number-theoretic transforms modulo 998244353.
// A load is written as it is accepted; a read registers its beat in ST_READ before idle returns.
// Multiply, size n: 3 transforms (A and B forward, product inverse), padding, pointwise product
//   and scaling; each modular product uses the 30-step serial multiplier.
// Carry pass: per product digit, load, divide (reciprocal multiply by the digit base), write.
// aresetn (synchronous) clears lengths, flags, read pointer; RAMs are not cleared.
module ntt_decimal_multiplier_top
    import ntt_dm_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS,
    parameter int DIGIT_BASE = DEFAULT_DIGIT_BASE
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,  // digit[3:0], a_negative[4], b_negative[5]
    input  logic [1:0] s_tuser,  // cmd[1:0]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,  // product_digit[3:0], product_negative[4], overflow_error[5]
    output logic       m_tlast
);

    localparam int WAW    = $clog2(2 * MAX_DIGITS);
    localparam int WDEPTH = 1 << WAW;
    localparam int IW     = WAW + 1;
    localparam int PD     = 2 * MAX_DIGITS;
    localparam int PAW    = $clog2(PD);
    localparam int CNW    = $clog2(PD + 1);
    localparam int LW     = $clog2(MAX_DIGITS + 1);
    localparam int SW     = $clog2(WAW + 2);
    localparam int RL     = $clog2(DIGIT_BASE);
    localparam int RK     = CARRY_W + RL;
    localparam logic [31:0] RECIP = 32'(((64'd1 << RK) / 64'(DIGIT_BASE)) + 64'd1);

    localparam logic [1:0] PH_FWD_A = 2'd0;
    localparam logic [1:0] PH_FWD_B = 2'd1;
    localparam logic [1:0] PH_INV_A = 2'd2;

    state_t state_reg, state_next, ret_reg, ret_next;
    logic [LW-1:0]      la_reg, la_next, lb_reg, lb_next;
    logic [CNW-1:0]     plen_reg, plen_next, ptr_reg, ptr_next;
    logic [CNW-1:0]     cnt_reg, cnt_next, nz_reg, nz_next;
    logic               neg_reg, neg_next, ovf_reg, ovf_next, sgn_reg, sgn_next;
    logic [IW-1:0]      n_reg, n_next, i_reg, i_next, blk_reg, blk_next, k_reg, k_next;
    logic [SW-1:0]      logn_reg, logn_next, s_reg, s_next;
    logic [1:0]         phase_reg, phase_next;
    logic [MW-1:0]      mx_reg, mx_next, my_reg, my_next, r_reg, r_next;
    logic [MW-1:0]      u_reg, u_next, w_reg, w_next, step_reg, step_next;
    logic [MW-1:0]      pbase_reg, pbase_next, pacc_reg, pacc_next, pexp_reg, pexp_next;
    logic [MW-1:0]      x_reg, x_next;
    logic [CARRY_W-1:0] carry_reg, carry_next, dq_reg, dq_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [4:0]         mcnt_reg, mcnt_next;
    logic               m_valid_reg, m_valid_next, m_last_reg, m_last_next;
    logic               m_neg_reg, m_neg_next, m_ovf_reg, m_ovf_next;
    logic [DIGIT_W-1:0] m_digit_reg, m_digit_next;

    logic               accept;
    cmd_t               cmd;
    logic [DIGIT_W-1:0] in_digit, dsat;
    logic               sel_b, inverse;
    logic [IW-1:0]      len_tot, j_idx, idx, hidx, half_w, len_w;
    logic [WAW-1:0]     rev_full;
    logic [MW-1:0]      ninv, a_dout, b_dout, dout_act, mul_res, add_res, sub_res;
    logic [31:0]        mul_sum;
    logic [30:0]        add_sum;
    logic [63:0]        div_prod;
    logic [CARRY_W-1:0] div_q;
    logic [DIGIT_W-1:0] div_rem;
    logic               cy_done, bf_last;

    logic               a_we, b_we, p_we;
    logic [WAW-1:0]     ram_waddr, ram_raddr;
    logic [MW-1:0]      ram_wdata;
    logic [PAW-1:0]     p_waddr;
    logic [DIGIT_W-1:0] p_wdata, p_dout;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tuser);
    assign in_digit = s_tdata[3:0];
    assign dsat     = (in_digit >= DIGIT_W'(DIGIT_BASE)) ? DIGIT_W'(DIGIT_BASE - 1) : in_digit;

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {2'b00, m_ovf_reg, m_neg_reg, m_digit_reg};

    assign sel_b   = (phase_reg == PH_FWD_B);
    assign inverse = (phase_reg == PH_INV_A);
    assign len_tot = IW'(la_reg) + IW'(lb_reg) - IW'(1);
    assign half_w  = IW'(1) << (s_reg - SW'(1));
    assign len_w   = IW'(1) << s_reg;
    assign idx     = blk_reg + k_reg;
    assign hidx    = idx + half_w;
    assign ninv    = MOD_P - ((MOD_P - MW'(1)) >> logn_reg);
    assign dout_act = sel_b ? b_dout : a_dout;
    assign bf_last = (blk_reg + len_w) >= n_reg;
    assign cy_done = (cnt_reg >= CNW'(PD)) || ((i_reg >= len_tot) && (carry_reg == '0));

    always_comb begin
        for (int b = 0; b < WAW; b++) begin
            rev_full[b] = i_reg[WAW-1-b];
        end
    end
    assign j_idx = IW'(rev_full >> (WAW - int'(logn_reg)));

    // Serial modular multiply step: r = 2r + bit*x, reduced below the modulus
    always_comb begin
        mul_sum = {1'b0, r_reg, 1'b0} + (my_reg[MW-1] ? 32'(mx_reg) : 32'd0);
        if (mul_sum >= 32'(2 * 64'(MOD_P))) begin
            mul_res = MW'(mul_sum - 32'(2 * 64'(MOD_P)));
        end else if (mul_sum >= 32'(MOD_P)) begin
            mul_res = MW'(mul_sum - 32'(MOD_P));
        end else begin
            mul_res = MW'(mul_sum);
        end
    end

    always_comb begin
        add_sum = 31'(u_reg) + 31'(r_reg);
        add_res = (add_sum >= 31'(MOD_P)) ? MW'(add_sum - 31'(MOD_P)) : MW'(add_sum);
        sub_res = (u_reg >= r_reg) ? (u_reg - r_reg) : (u_reg + MOD_P - r_reg);
    end

    // Quotient by the digit base through a rounded-up reciprocal
    assign div_prod = {32'd0, 32'(dq_reg)} * {32'd0, RECIP};
    assign div_q    = CARRY_W'(div_prod >> RK);
    assign div_rem  = DIGIT_W'(dq_reg - CARRY_W'(div_q * CARRY_W'(DIGIT_BASE)));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (cmd)
                        CMD_MULTIPLY: begin
                            state_next = (la_reg == '0 || lb_reg == '0) ? ST_EMPTY : ST_SIZE;
                        end
                        CMD_READ: state_next = ST_READ;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:   state_next = (m_valid_reg && !m_tready) ? ST_READ : ST_IDLE;
            ST_EMPTY:  state_next = ST_IDLE;
            ST_SIZE:   state_next = (n_reg < len_tot) ? ST_SIZE : ST_PAD;
            ST_PAD:    state_next = (i_reg < n_reg) ? ST_PAD : ST_BR_IDX;
            ST_BR_IDX: begin
                if (i_reg >= n_reg) begin
                    state_next = ST_STAGE;
                end else if (i_reg < j_idx) begin
                    state_next = ST_BR_RI;
                end
            end
            ST_BR_RI:  state_next = ST_BR_RJ;
            ST_BR_RJ:  state_next = ST_BR_WI;
            ST_BR_WI:  state_next = ST_BR_WJ;
            ST_BR_WJ:  state_next = ST_BR_IDX;
            ST_STAGE: begin
                if (s_reg > logn_reg) begin
                    case (phase_reg)
                        PH_FWD_A: state_next = ST_BR_IDX;
                        PH_FWD_B: state_next = ST_PW_RD;
                        default:  state_next = ST_SC_RD;
                    endcase
                end else begin
                    state_next = ST_POW_CHK;
                end
            end
            ST_POW_CHK: begin
                if (pexp_reg == '0) begin
                    state_next = ST_BF_RU;
                end else if (pexp_reg[0]) begin
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_POW_SQ;
                end
            end
            ST_POW_ACC:  state_next = ST_POW_SQ;
            ST_POW_SQ:   state_next = ST_MUL;
            ST_POW_BASE: state_next = ST_POW_CHK;
            ST_BF_RU:    state_next = ST_BF_RV;
            ST_BF_RV:    state_next = ST_BF_MUL;
            ST_BF_MUL:   state_next = ST_MUL;
            ST_BF_WU:    state_next = ST_BF_WV;
            ST_BF_WV:    state_next = bf_last ? ST_MUL : ST_BF_RU;
            ST_W_UPD:    state_next = ((k_reg + IW'(1)) >= half_w) ? ST_STAGE : ST_BF_RU;
            ST_PW_RD:    state_next = (i_reg < n_reg) ? ST_PW_MUL : ST_BR_IDX;
            ST_PW_MUL:   state_next = ST_MUL;
            ST_PW_WR:    state_next = ST_PW_RD;
            ST_SC_RD:    state_next = (i_reg < n_reg) ? ST_SC_MUL : ST_CY_NEXT;
            ST_SC_MUL:   state_next = ST_MUL;
            ST_SC_WR:    state_next = ST_SC_RD;
            ST_CY_NEXT: begin
                if (cy_done) begin
                    state_next = ST_FINISH;
                end else if (i_reg < len_tot) begin
                    state_next = ST_CY_LD;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_CY_LD:  state_next = ST_DIV;
            ST_DIV:    state_next = ST_CY_WR;
            ST_CY_WR:  state_next = ST_CY_NEXT;
            ST_MUL:    state_next = (mcnt_reg == 5'(MW - 1)) ? ret_reg : ST_MUL;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ret_next = ret_reg;
        la_next = la_reg;
        lb_next = lb_reg;
        plen_next = plen_reg;
        ptr_next = ptr_reg;
        cnt_next = cnt_reg;
        nz_next = nz_reg;
        neg_next = neg_reg;
        ovf_next = ovf_reg;
        sgn_next = sgn_reg;
        n_next = n_reg;
        i_next = i_reg;
        blk_next = blk_reg;
        k_next = k_reg;
        logn_next = logn_reg;
        s_next = s_reg;
        phase_next = phase_reg;
        mx_next = mx_reg;
        my_next = my_reg;
        r_next = r_reg;
        u_next = u_reg;
        w_next = w_reg;
        step_next = step_reg;
        pbase_next = pbase_reg;
        pacc_next = pacc_reg;
        pexp_next = pexp_reg;
        x_next = x_reg;
        carry_next = carry_reg;
        dq_next = dq_reg;
        rem_next = rem_reg;
        mcnt_next = mcnt_reg;
        m_valid_next = m_valid_reg;
        m_last_next = m_last_reg;
        m_neg_next = m_neg_reg;
        m_ovf_next = m_ovf_reg;
        m_digit_next = m_digit_reg;
        a_we = 1'b0;
        b_we = 1'b0;
        p_we = 1'b0;
        ram_waddr = i_reg[WAW-1:0];
        ram_raddr = i_reg[WAW-1:0];
        ram_wdata = '0;
        p_waddr = cnt_reg[PAW-1:0];
        p_wdata = rem_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (cmd)
                        CMD_LOAD_A: begin
                            if (la_reg == '0 && lb_reg == '0) begin
                                ovf_next = 1'b0;
                            end
                            if (la_reg < LW'(MAX_DIGITS)) begin
                                ram_waddr = WAW'(la_reg);
                                ram_wdata = MW'(dsat);
                                a_we = 1'b1;
                                la_next = la_reg + LW'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        CMD_LOAD_B: begin
                            if (la_reg == '0 && lb_reg == '0) begin
                                ovf_next = 1'b0;
                            end
                            if (lb_reg < LW'(MAX_DIGITS)) begin
                                ram_waddr = WAW'(lb_reg);
                                ram_wdata = MW'(dsat);
                                b_we = 1'b1;
                                lb_next = lb_reg + LW'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        CMD_MULTIPLY: begin
                            sgn_next = s_tdata[4] ^ s_tdata[5];
                            n_next = IW'(1);
                            logn_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_ovf_next = ovf_reg;
                    if (plen_reg == '0 || ptr_reg >= plen_reg) begin
                        m_digit_next = '0;
                        m_neg_next = 1'b0;
                        m_last_next = 1'b1;
                        ptr_next = '0;
                    end else begin
                        m_digit_next = p_dout;
                        m_neg_next = neg_reg;
                        if ((ptr_reg + CNW'(1)) >= plen_reg) begin
                            m_last_next = 1'b1;
                            ptr_next = '0;
                        end else begin
                            m_last_next = 1'b0;
                            ptr_next = ptr_reg + CNW'(1);
                        end
                    end
                end
            end
            ST_EMPTY: begin
                p_we = 1'b1;
                p_waddr = '0;
                p_wdata = '0;
                plen_next = CNW'(1);
                neg_next = 1'b0;
                ptr_next = '0;
                la_next = '0;
                lb_next = '0;
            end
            ST_SIZE: begin
                if (n_reg < len_tot) begin
                    n_next = n_reg << 1;
                    logn_next = logn_reg + SW'(1);
                end else begin
                    i_next = '0;
                end
            end
            ST_PAD: begin
                if (i_reg < n_reg) begin
                    a_we = (i_reg >= IW'(la_reg));
                    b_we = (i_reg >= IW'(lb_reg));
                    i_next = i_reg + IW'(1);
                end else begin
                    phase_next = PH_FWD_A;
                    i_next = IW'(1);
                end
            end
            ST_BR_IDX: begin
                if (i_reg >= n_reg) begin
                    s_next = SW'(1);
                end else if (!(i_reg < j_idx)) begin
                    i_next = i_reg + IW'(1);
                end
            end
            ST_BR_RJ: begin
                ram_raddr = j_idx[WAW-1:0];
                x_next = dout_act;
            end
            ST_BR_WI: begin
                ram_wdata = dout_act;
                a_we = !sel_b;
                b_we = sel_b;
            end
            ST_BR_WJ: begin
                ram_waddr = j_idx[WAW-1:0];
                ram_wdata = x_reg;
                a_we = !sel_b;
                b_we = sel_b;
                i_next = i_reg + IW'(1);
            end
            ST_STAGE: begin
                if (s_reg > logn_reg) begin
                    case (phase_reg)
                        PH_FWD_A: begin
                            phase_next = PH_FWD_B;
                            i_next = IW'(1);
                        end
                        default: i_next = '0;
                    endcase
                end else begin
                    pexp_next = (MOD_P - MW'(1)) >> s_reg;
                    pbase_next = inverse ? ROOT_INV : ROOT_FWD;
                    pacc_next = MW'(1);
                end
            end
            ST_POW_CHK: begin
                if (pexp_reg == '0) begin
                    step_next = pacc_reg;
                    k_next = '0;
                    blk_next = '0;
                    w_next = MW'(1);
                end else if (pexp_reg[0]) begin
                    mx_next = pacc_reg;
                    my_next = pbase_reg;
                    r_next = '0;
                    mcnt_next = '0;
                    ret_next = ST_POW_ACC;
                end
            end
            ST_POW_ACC: pacc_next = r_reg;
            ST_POW_SQ: begin
                mx_next = pbase_reg;
                my_next = pbase_reg;
                r_next = '0;
                mcnt_next = '0;
                ret_next = ST_POW_BASE;
            end
            ST_POW_BASE: begin
                pbase_next = r_reg;
                pexp_next = pexp_reg >> 1;
            end
            ST_BF_RU: ram_raddr = idx[WAW-1:0];
            ST_BF_RV: begin
                ram_raddr = hidx[WAW-1:0];
                u_next = dout_act;
            end
            ST_BF_MUL: begin
                mx_next = dout_act;
                my_next = w_reg;
                r_next = '0;
                mcnt_next = '0;
                ret_next = ST_BF_WU;
            end
            ST_BF_WU: begin
                ram_waddr = idx[WAW-1:0];
                ram_wdata = add_res;
                a_we = !sel_b;
                b_we = sel_b;
            end
            ST_BF_WV: begin
                ram_waddr = hidx[WAW-1:0];
                ram_wdata = sub_res;
                a_we = !sel_b;
                b_we = sel_b;
                blk_next = blk_reg + len_w;
                if (bf_last) begin
                    mx_next = w_reg;
                    my_next = step_reg;
                    r_next = '0;
                    mcnt_next = '0;
                    ret_next = ST_W_UPD;
                end
            end
            ST_W_UPD: begin
                w_next = r_reg;
                k_next = k_reg + IW'(1);
                blk_next = '0;
                if ((k_reg + IW'(1)) >= half_w) begin
                    s_next = s_reg + SW'(1);
                end
            end
            ST_PW_RD: begin
                if (!(i_reg < n_reg)) begin
                    phase_next = PH_INV_A;
                    i_next = IW'(1);
                end
            end
            ST_PW_MUL: begin
                mx_next = a_dout;
                my_next = b_dout;
                r_next = '0;
                mcnt_next = '0;
                ret_next = ST_PW_WR;
            end
            ST_PW_WR: begin
                ram_wdata = r_reg;
                a_we = 1'b1;
                i_next = i_reg + IW'(1);
            end
            ST_SC_RD: begin
                if (!(i_reg < n_reg)) begin
                    i_next = '0;
                    carry_next = '0;
                    cnt_next = '0;
                    nz_next = '0;
                end
            end
            ST_SC_MUL: begin
                mx_next = a_dout;
                my_next = ninv;
                r_next = '0;
                mcnt_next = '0;
                ret_next = ST_SC_WR;
            end
            ST_SC_WR: begin
                ram_wdata = r_reg;
                a_we = 1'b1;
                i_next = i_reg + IW'(1);
            end
            ST_CY_NEXT: begin
                if (!cy_done && !(i_reg < len_tot)) begin
                    dq_next = carry_reg;
                    rem_next = '0;
                end
            end
            ST_CY_LD: begin
                dq_next = CARRY_W'(a_dout) + carry_reg;
                rem_next = '0;
            end
            ST_DIV: begin
                dq_next = div_q;
                rem_next = div_rem;
            end
            ST_CY_WR: begin
                p_we = 1'b1;
                carry_next = dq_reg;
                cnt_next = cnt_reg + CNW'(1);
                if (rem_reg != '0) begin
                    nz_next = cnt_reg + CNW'(1);
                end
                if (i_reg < len_tot) begin
                    i_next = i_reg + IW'(1);
                end
            end
            ST_MUL: begin
                r_next = mul_res;
                my_next = my_reg << 1;
                mcnt_next = mcnt_reg + 5'd1;
            end
            ST_FINISH: begin
                plen_next = (nz_reg == '0) ? CNW'(1) : nz_reg;
                neg_next = sgn_reg && (nz_reg != '0);
                ptr_next = '0;
                la_next = '0;
                lb_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            la_reg <= '0;
            lb_reg <= '0;
            plen_reg <= '0;
            ptr_reg <= '0;
            neg_reg <= 1'b0;
            ovf_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            la_reg <= la_next;
            lb_reg <= lb_next;
            plen_reg <= plen_next;
            ptr_reg <= ptr_next;
            neg_reg <= neg_next;
            ovf_reg <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ret_reg <= ret_next;
        cnt_reg <= cnt_next;
        nz_reg <= nz_next;
        sgn_reg <= sgn_next;
        n_reg <= n_next;
        i_reg <= i_next;
        blk_reg <= blk_next;
        k_reg <= k_next;
        logn_reg <= logn_next;
        s_reg <= s_next;
        phase_reg <= phase_next;
        mx_reg <= mx_next;
        my_reg <= my_next;
        r_reg <= r_next;
        u_reg <= u_next;
        w_reg <= w_next;
        step_reg <= step_next;
        pbase_reg <= pbase_next;
        pacc_reg <= pacc_next;
        pexp_reg <= pexp_next;
        x_reg <= x_next;
        carry_reg <= carry_next;
        dq_reg <= dq_next;
        rem_reg <= rem_next;
        mcnt_reg <= mcnt_next;
        m_last_reg <= m_last_next;
        m_neg_reg <= m_neg_next;
        m_ovf_reg <= m_ovf_next;
        m_digit_reg <= m_digit_next;
    end

    ntt_dm_ram #(.WIDTH(MW), .DEPTH(WDEPTH)) u_work_a (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (a_dout)
    );

    ntt_dm_ram #(.WIDTH(MW), .DEPTH(WDEPTH)) u_work_b (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (b_dout)
    );

    ntt_dm_ram #(.WIDTH(DIGIT_W), .DEPTH(PD)) u_product (
        .aclk  (aclk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (ptr_reg[PAW-1:0]),
        .rdata (p_dout)
    );

    a_beat_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("result beat changed while stalled");

    a_len_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (la_reg <= LW'(MAX_DIGITS)) && (lb_reg <= LW'(MAX_DIGITS)))
        else $error("operand length beyond capacity");

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (plen_reg == '0) || (ptr_reg < plen_reg))
        else $error("read pointer beyond product length");

    a_read_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |=> m_tvalid)
        else $error("read did not produce a result beat");

endmodule

// ===== tb/sv/tb_ntt_decimal_multiplier_top.sv =====
// Testbench for the transform-based signed decimal multiplier: directed table plus random runs.
`timescale 1ns / 100ps

module tb_ntt_decimal_multiplier_top;
    import ntt_dm_pkg::*;

    localparam int DIGITS_MAX = DEFAULT_MAX_DIGITS;
    localparam int RADIX      = DEFAULT_DIGIT_BASE;
    localparam int STALL_MAX  = 400000;
    localparam int ITEMS      = 1350;

    typedef struct packed {
        logic [3:0] digit;
        logic       neg;
        logic       last;
        logic       ovf;
    } beat_t;

    typedef struct packed {
        cmd_t       c;
        logic [3:0] d;
        logic       an;
        logic       bn;
        int         reps;
        bit         typed;
        beat_t      want;
    } row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic       m_tvalid;
    logic       m_tready = 1'b1;
    logic [7:0] m_tdata;
    logic       m_tlast;

    beat_t      pending_q[$];
    int         mismatches = 0;
    int         sent = 0;
    int         stall_cycles = 0;
    bit         calm = 1'b0;

    int         op_a[$];
    int         op_b[$];
    logic [3:0] prod_digits[0:2*DIGITS_MAX-1];
    int         prod_len = 0;
    int         rd_ptr = 0;
    logic       prod_neg = 1'b0;
    logic       load_ovf = 1'b0;

    row_t rows[20] = '{
        '{CMD_READ,     4'd0,  1'b0, 1'b0, 1,    1'b1, '{4'd0, 1'b0, 1'b1, 1'b0}},
        '{CMD_LOAD_A,   4'd9,  1'b1, 1'b1, 1,    1'b0, '0},
        '{CMD_LOAD_A,   4'd15, 1'b0, 1'b1, 1,    1'b0, '0},
        '{CMD_LOAD_B,   4'd9,  1'b1, 1'b0, 1,    1'b0, '0},
        '{CMD_MULTIPLY, 4'd0,  1'b1, 1'b0, 1,    1'b0, '0},
        '{CMD_READ,     4'd15, 1'b1, 1'b1, 1,    1'b1, '{4'd1, 1'b1, 1'b0, 1'b0}},
        '{CMD_READ,     4'd0,  1'b0, 1'b0, 1,    1'b1, '{4'd9, 1'b1, 1'b0, 1'b0}},
        '{CMD_READ,     4'd0,  1'b0, 1'b0, 1,    1'b1, '{4'd8, 1'b1, 1'b1, 1'b0}},
        '{CMD_READ,     4'd0,  1'b0, 1'b0, 1,    1'b1, '{4'd1, 1'b1, 1'b0, 1'b0}},
        '{CMD_LOAD_B,   4'd5,  1'b0, 1'b0, 1,    1'b0, '0},
        '{CMD_MULTIPLY, 4'd0,  1'b1, 1'b0, 1,    1'b0, '0},
        '{CMD_READ,     4'd0,  1'b0, 1'b0, 1,    1'b1, '{4'd0, 1'b0, 1'b1, 1'b0}},
        '{CMD_LOAD_A,   4'd0,  1'b0, 1'b0, 1,    1'b0, '0},
        '{CMD_LOAD_B,   4'd0,  1'b0, 1'b0, 1,    1'b0, '0},
        '{CMD_MULTIPLY, 4'd0,  1'b1, 1'b1, 1,    1'b0, '0},
        '{CMD_LOAD_A,   4'd7,  1'b0, 1'b0, 1025, 1'b0, '0},
        '{CMD_MULTIPLY, 4'd0,  1'b1, 1'b1, 1,    1'b0, '0},
        '{CMD_READ,     4'd0,  1'b0, 1'b0, 1,    1'b1, '{4'd0, 1'b0, 1'b1, 1'b1}},
        '{CMD_LOAD_B,   4'd3,  1'b0, 1'b0, 1,    1'b0, '0},
        '{CMD_LOAD_A,   4'd2,  1'b0, 1'b1, 1,    1'b0, '0}
    };

    ntt_decimal_multiplier_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    task automatic multiply_digits(input logic an, input logic bn);
        longint conv[$];
        longint carry;
        int     cnt;
        if (op_a.size() == 0 || op_b.size() == 0) begin
            prod_digits[0] = 4'd0;
            cnt = 1;
        end else begin
            conv = {};
            for (int i = 0; i < op_a.size() + op_b.size() - 1; i++) conv.insert(conv.size(), 0);
            foreach (op_a[i]) foreach (op_b[j]) conv[i+j] += op_a[i] * op_b[j];
            carry = 0;
            cnt = 0;
            foreach (conv[i]) begin
                carry += conv[i];
                prod_digits[cnt++] = 4'(carry % RADIX);
                carry /= RADIX;
            end
            while (carry != 0) begin
                prod_digits[cnt++] = 4'(carry % RADIX);
                carry /= RADIX;
            end
            while (cnt > 1 && prod_digits[cnt-1] == 4'd0) cnt--;
        end
        prod_len = cnt;
        rd_ptr = 0;
        prod_neg = (an != bn) && !(cnt == 1 && prod_digits[0] == 4'd0);
        op_a = {};
        op_b = {};
    endtask

    task automatic predict_product(input cmd_t c, input logic [3:0] d, input logic an,
                                   input logic bn, output bit has, output beat_t r);
        int dv;
        has = 1'b0;
        r = '0;
        dv = (d >= RADIX) ? RADIX - 1 : int'(d);
        case (c)
            CMD_LOAD_A, CMD_LOAD_B: begin
                if (op_a.size() == 0 && op_b.size() == 0) load_ovf = 1'b0;
                if (c == CMD_LOAD_A) begin
                    if (op_a.size() < DIGITS_MAX) op_a.insert(op_a.size(), dv);
                    else load_ovf = 1'b1;
                end else begin
                    if (op_b.size() < DIGITS_MAX) op_b.insert(op_b.size(), dv);
                    else load_ovf = 1'b1;
                end
            end
            CMD_MULTIPLY: multiply_digits(an, bn);
            default: begin
                has = 1'b1;
                r.ovf = load_ovf;
                if (prod_len == 0 || rd_ptr >= prod_len) begin
                    r.last = 1'b1;
                    rd_ptr = 0;
                end else begin
                    r.digit = prod_digits[rd_ptr];
                    r.neg = prod_neg;
                    r.last = (rd_ptr + 1 >= prod_len);
                    rd_ptr = r.last ? 0 : rd_ptr + 1;
                end
            end
        endcase
    endtask

    task automatic send(input cmd_t c, input logic [3:0] d, input logic an, input logic bn,
                        input bit typed, input beat_t want);
        beat_t r;
        bit    has;
        if (!calm && $urandom_range(0, 99) < 14) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= c;
        s_tdata <= {2'b00, bn, an, d};
        do @(posedge aclk); while (!s_tready);
        predict_product(c, d, an, bn, has, r);
        if (has) pending_q.insert(pending_q.size(), typed ? want : r);
        sent++;
    endtask

    function automatic logic [3:0] rand_digit();
        return 4'($urandom_range(0, 99) < 80 ? $urandom_range(0, 9) : $urandom_range(10, 15));
    endfunction

    task automatic run_product();
        int la;
        int lb;
        int reads;
        la = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
        lb = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
        while (la + lb > 0) begin
            if (lb == 0 || (la > 0 && $urandom_range(0, 1))) begin
                send(CMD_LOAD_A, rand_digit(), 1'($urandom), 1'($urandom), 1'b0, '0);
                la--;
            end else begin
                send(CMD_LOAD_B, rand_digit(), 1'($urandom), 1'($urandom), 1'b0, '0);
                lb--;
            end
        end
        send(CMD_MULTIPLY, 4'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
        reads = prod_len + $urandom_range(0, 3);
        repeat (reads) send(CMD_READ, 4'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
    endtask

    always @(posedge aclk) begin
        if (aresetn) m_tready <= calm || ($urandom_range(0, 99) >= 14);
    end

    always @(posedge aclk) begin
        beat_t got;
        beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[3:0], m_tdata[4], m_tlast, m_tdata[5]};
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat %p", got);
            end else begin
                want = pending_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_MAX) begin
            $display("tb_ntt_decimal_multiplier_top: done, errors");
            $finish;
        end
    end

    initial begin
        int base;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (rows[i]) begin
            repeat (rows[i].reps) begin
                send(rows[i].c, rows[i].d, rows[i].an, rows[i].bn, rows[i].typed, rows[i].want);
            end
        end
        send(CMD_MULTIPLY, 4'd0, 1'b0, 1'b1, 1'b0, '0);
        send(CMD_READ, 4'd0, 1'b0, 1'b0, 1'b1, '{4'd6, 1'b1, 1'b1, 1'b0});
        send(CMD_READ, 4'd0, 1'b0, 1'b0, 1'b1, '{4'd6, 1'b1, 1'b1, 1'b0});
        base = sent;
        while (sent < ITEMS) begin
            calm = (sent - base > 100) && (sent - base < 200);
            if ($urandom_range(0, 99) < 85) begin
                run_product();
            end else begin
                repeat ($urandom_range(1, 5)) begin
                    send(cmd_t'($urandom_range(0, 3)), 4'($urandom), 1'($urandom),
                         1'($urandom), 1'b0, '0);
                end
            end
        end
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_ntt_decimal_multiplier_top: done, clean");
        end else begin
            $display("tb_ntt_decimal_multiplier_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/ntt_dm_pkg.sv
sv/ntt_dm_ram.sv
sv/ntt_decimal_multiplier_top.sv
tb/sv/tb_ntt_decimal_multiplier_top.sv
